// ===== hdl/qrg_pkg.sv =====
// qrg_pkg: shared types, codes and helpers of the quadrant rotation gesture detector.
// Used by qrg_quad_classify, qrg_tracker_core and quadrant_rotation_gesture_detector.
`timescale 1ns / 1ps
`default_nettype none

package qrg_pkg;

    localparam int CoordWidth = 16;
    localparam int ThrWidth   = 15;
    localparam int CountWidth = 16;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;

    // quadrant codes, clockwise order
    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_PM = 2'd1;
    localparam logic [1:0] QUAD_MM = 2'd2;
    localparam logic [1:0] QUAD_MP = 2'd3;

    localparam logic [CountWidth-1:0] LATCH_STEPS   = 16'd5;
    localparam logic [ThrWidth-1:0]   THR_RESET     = 15'd64;
    localparam logic [1:0]            TURN_PHASE    = 2'd1;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } quad_t;

    // packed lowest field last so the struct maps directly onto tdata
    typedef struct packed {
        logic                  translate_restart;
        logic                  turn_pulse;
        logic [CountWidth-1:0] turns_left;
        logic [CountWidth-1:0] turns_right;
        logic [1:0]            rotation;
    } result_t;

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        sat_inc = (v == {CountWidth{1'b1}}) ? v : v + {{(CountWidth-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/qrg_quad_classify.sv =====
// qrg_quad_classify: maps one cursor sample to a quadrant against the threshold.
// Depends on qrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrg_quad_classify (
    input  wire logic signed [qrg_pkg::CoordWidth-1:0] cursor_x,
    input  wire logic signed [qrg_pkg::CoordWidth-1:0] cursor_y,
    input  wire logic        [qrg_pkg::ThrWidth-1:0]   threshold,
    output qrg_pkg::quad_t                             quad
);

    logic signed [qrg_pkg::CoordWidth:0] xs;
    logic signed [qrg_pkg::CoordWidth:0] ys;
    logic signed [qrg_pkg::CoordWidth:0] thr_pos;
    logic signed [qrg_pkg::CoordWidth:0] thr_neg;
    logic x_pos, x_neg, y_pos, y_neg;

    always_comb begin
        xs      = {cursor_x[qrg_pkg::CoordWidth-1], cursor_x};
        ys      = {cursor_y[qrg_pkg::CoordWidth-1], cursor_y};
        thr_pos = {2'b00, threshold};
        thr_neg = -thr_pos;
        x_pos   = xs > thr_pos;
        x_neg   = xs < thr_neg;
        y_pos   = ys > thr_pos;
        y_neg   = ys < thr_neg;

        quad.valid = 1'b1;
        if (x_pos && y_pos) begin
            quad.code = qrg_pkg::QUAD_PP;
        end else if (x_pos && y_neg) begin
            quad.code = qrg_pkg::QUAD_PM;
        end else if (x_neg && y_neg) begin
            quad.code = qrg_pkg::QUAD_MM;
        end else if (x_neg && y_pos) begin
            quad.code = qrg_pkg::QUAD_MP;
        end else begin
            quad.valid = 1'b0;
            quad.code  = qrg_pkg::QUAD_PP;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qrg_tracker_core.sv =====
// qrg_tracker_core: clockwise and counter-clockwise trackers, direction latch, turn counters.
// Depends on qrg_pkg. State advances once per step_en.
`timescale 1ns / 1ps
`default_nettype none

module qrg_tracker_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic             idle,
    input  wire qrg_pkg::quad_t   quad,
    output qrg_pkg::result_t      result
);

    localparam int CW = qrg_pkg::CountWidth;

    logic [1:0]      mode_reg, mode_next;
    qrg_pkg::quad_t  r_prev_reg, r_prev_next;
    qrg_pkg::quad_t  l_prev_reg, l_prev_next;
    logic [CW-1:0]   r_steps_reg, r_steps_next;
    logic [CW-1:0]   l_steps_reg, l_steps_next;
    logic [CW-1:0]   r_turns_reg, r_turns_next;
    logic [CW-1:0]   l_turns_reg, l_turns_next;

    logic [1:0]      mode_cur;
    qrg_pkg::quad_t  r_prev_cur, l_prev_cur;
    logic [CW-1:0]   r_steps_cur, l_steps_cur, r_turns_cur, l_turns_cur;
    logic [1:0]      r_pred, l_pred;
    logic            r_acc, l_acc, r_moved, l_moved;
    logic [CW-1:0]   r_steps_acc, l_steps_acc;
    logic            pulse, restart;

    always_comb begin
        // idle sample: analyse from cleared state
        mode_cur    = idle ? qrg_pkg::MODE_NONE : mode_reg;
        r_prev_cur  = idle ? '0 : r_prev_reg;
        l_prev_cur  = idle ? '0 : l_prev_reg;
        r_steps_cur = idle ? '0 : r_steps_reg;
        l_steps_cur = idle ? '0 : l_steps_reg;
        r_turns_cur = idle ? '0 : r_turns_reg;
        l_turns_cur = idle ? '0 : l_turns_reg;

        r_pred  = quad.code - 2'd1;
        l_pred  = quad.code + 2'd1;
        r_acc   = quad.valid && (!r_prev_cur.valid || r_prev_cur.code == r_pred);
        l_acc   = quad.valid && (!l_prev_cur.valid || l_prev_cur.code == l_pred);
        r_moved = r_acc && r_prev_cur.valid;
        l_moved = l_acc && l_prev_cur.valid;

        r_steps_acc = r_acc ? qrg_pkg::sat_inc(r_steps_cur) : r_steps_cur;
        l_steps_acc = l_acc ? qrg_pkg::sat_inc(l_steps_cur) : l_steps_cur;

        // left move applies to the right tracker first
        r_prev_next  = (r_acc || l_moved) ? quad : r_prev_cur;
        r_steps_next = l_moved ? '0 : r_steps_acc;
        if (r_moved) begin
            l_prev_next = l_moved ? '0 : quad;
        end else begin
            l_prev_next = l_acc ? quad : l_prev_cur;
        end
        l_steps_next = r_moved ? '0 : l_steps_acc;

        mode_next    = mode_cur;
        r_turns_next = r_turns_cur;
        l_turns_next = l_turns_cur;
        restart      = 1'b0;
        if (r_steps_next >= qrg_pkg::LATCH_STEPS) begin
            mode_next    = qrg_pkg::MODE_RIGHT;
            l_turns_next = '0;
            restart      = 1'b1;
        end
        if (l_steps_next >= qrg_pkg::LATCH_STEPS) begin
            mode_next    = qrg_pkg::MODE_LEFT;
            r_turns_next = '0;
            restart      = 1'b1;
        end

        pulse = 1'b0;
        if (l_moved && mode_next == qrg_pkg::MODE_LEFT
                && l_steps_next[1:0] == qrg_pkg::TURN_PHASE) begin
            l_turns_next = qrg_pkg::sat_inc(l_turns_next);
            pulse        = 1'b1;
        end
        if (r_moved && mode_next == qrg_pkg::MODE_RIGHT
                && r_steps_next[1:0] == qrg_pkg::TURN_PHASE) begin
            r_turns_next = qrg_pkg::sat_inc(r_turns_next);
            pulse        = 1'b1;
        end

        result.rotation          = mode_next;
        result.turns_right       = r_turns_next;
        result.turns_left        = l_turns_next;
        result.turn_pulse        = pulse;
        result.translate_restart = restart;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= qrg_pkg::MODE_NONE;
            r_prev_reg  <= '0;
            l_prev_reg  <= '0;
            r_steps_reg <= '0;
            l_steps_reg <= '0;
            r_turns_reg <= '0;
            l_turns_reg <= '0;
        end else if (step_en) begin
            mode_reg    <= mode_next;
            r_prev_reg  <= r_prev_next;
            l_prev_reg  <= l_prev_next;
            r_steps_reg <= r_steps_next;
            l_steps_reg <= l_steps_next;
            r_turns_reg <= r_turns_next;
            l_turns_reg <= l_turns_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/quadrant_rotation_gesture_detector.sv =====
// Quadrant rotation gesture detector, top level.
// Depends on qrg_pkg, qrg_quad_classify and qrg_tracker_core.
//
// Usage:
//   s_ channel: one cursor sample per transaction. s_tdata holds cursor_x and
//   cursor_y, s_tuser the idle flag. An idle sample clears all tracker state
//   before the sample itself is analysed.
//   m_ channel: one result per sample, in order.
//   cfg_ channel: writes the 15-bit sensitivity threshold; always ready. Write
//   it only while no sample is in flight.
// Pipeline: an accepted sample is held in the input register; the classifier and
//   tracker update are combinational and are registered into the result register.
// Throughput: one sample per cycle while m_tready is high.
// Stall: while m_tready is low the result holds; one more sample waits in the
//   input register, then s_tready drops until the result is taken.
// Reset: aresetn low clears both channels, all tracker state, and sets the
//   threshold to 64.
`timescale 1ns / 1ps
`default_nettype none

module quadrant_rotation_gesture_detector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] cursor_x, [31:16] cursor_y
    input  wire logic        s_tuser,   // [0] gesture_idle
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] rotation, [17:2] turns_right, [33:18] turns_left,
    // [34] turn_pulse, [35] translate_restart, [39:36] zero
    output wire logic [39:0] m_tdata,
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [14:0] cfg_data
);

    logic                                 in_valid_reg, in_valid_next;
    logic signed [qrg_pkg::CoordWidth-1:0] in_x_reg;
    logic signed [qrg_pkg::CoordWidth-1:0] in_y_reg;
    logic                                 in_idle_reg;
    logic                                 out_valid_reg, out_valid_next;
    qrg_pkg::result_t                     out_data_reg;
    logic [qrg_pkg::ThrWidth-1:0]         thr_reg;

    logic             advance;
    logic             s_accept;
    qrg_pkg::quad_t   quad;
    qrg_pkg::result_t result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_data_reg};

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    qrg_quad_classify u_classify (
        .cursor_x  (in_x_reg),
        .cursor_y  (in_y_reg),
        .threshold (thr_reg),
        .quad      (quad)
    );

    qrg_tracker_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .idle    (in_idle_reg),
        .quad    (quad),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= qrg_pkg::THR_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_x_reg    <= s_tdata[15:0];
            in_y_reg    <= s_tdata[31:16];
            in_idle_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== sim/gesture_result_checker.sv =====
// gesture_result_checker: watches the sample, result and threshold channels of the
// quadrant rotation gesture detector. It predicts each result and compares it field by field.
// Depends on qrg_pkg for the result layout and the mode and quadrant codes.
`timescale 1ns / 1ps

module gesture_result_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] cursor_x, [31:16] cursor_y
    input  wire logic        s_tuser,   // [0] gesture_idle
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] rotation, [17:2] turns_right, [33:18] turns_left,
    // [34] turn_pulse, [35] translate_restart, [39:36] zero
    input  wire logic [39:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [14:0] cfg_data,
    output int               mismatches,
    output int               outstanding
);

    localparam int QUAD_NONE = -1;
    localparam int PRINT_CAP = 100;

    logic [qrg_pkg::ThrWidth-1:0]   threshold;
    logic [1:0]                     mode;
    int                             cw_pos, cw_prev, ccw_pos, ccw_prev;
    logic [qrg_pkg::CountWidth-1:0] cw_steps, ccw_steps, cw_turns, ccw_turns;
    qrg_pkg::result_t               expected_gesture_results[$];
    int                             result_index;

    function automatic logic [qrg_pkg::CountWidth-1:0] bump16(
            input logic [qrg_pkg::CountWidth-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_gesture();
        mode      = qrg_pkg::MODE_NONE;
        cw_pos    = QUAD_NONE;
        cw_prev   = QUAD_NONE;
        ccw_pos   = QUAD_NONE;
        ccw_prev  = QUAD_NONE;
        cw_steps  = '0;
        ccw_steps = '0;
        cw_turns  = '0;
        ccw_turns = '0;
    endfunction

    function automatic int quadrant_of(input logic signed [15:0] x, input logic signed [15:0] y);
        int xs;
        int ys;
        int t;
        xs = x;
        ys = y;
        t  = int'(threshold);
        if (xs > t && ys > t)
            return int'(qrg_pkg::QUAD_PP);
        if (xs > t && ys < -t)
            return int'(qrg_pkg::QUAD_PM);
        if (xs < -t && ys < -t)
            return int'(qrg_pkg::QUAD_MM);
        if (xs < -t && ys > t)
            return int'(qrg_pkg::QUAD_MP);
        return QUAD_NONE;
    endfunction

    function automatic qrg_pkg::result_t predict_gesture(input logic signed [15:0] x,
                                                         input logic signed [15:0] y,
                                                         input logic idle);
        int               q;
        logic             cw_moved;
        logic             ccw_moved;
        qrg_pkg::result_t r;
        cw_moved  = 1'b0;
        ccw_moved = 1'b0;
        r         = '0;
        if (idle)
            clear_gesture();
        q = quadrant_of(x, y);
        if (q != QUAD_NONE) begin
            if (cw_prev == QUAD_NONE || cw_prev == (q + 3) % 4) begin
                cw_moved = (cw_prev != QUAD_NONE);
                cw_pos   = q;
                cw_prev  = q;
                cw_steps = bump16(cw_steps);
            end
            if (ccw_prev == QUAD_NONE || ccw_prev == (q + 1) % 4) begin
                ccw_moved = (ccw_prev != QUAD_NONE);
                ccw_pos   = q;
                ccw_prev  = q;
                ccw_steps = bump16(ccw_steps);
            end
        end
        // left move hits the right tracker first
        if (ccw_moved) begin
            cw_pos   = QUAD_NONE;
            cw_steps = '0;
            cw_prev  = ccw_pos;
        end
        if (cw_moved) begin
            ccw_pos   = QUAD_NONE;
            ccw_steps = '0;
            ccw_prev  = cw_pos;
        end
        if (cw_steps >= qrg_pkg::LATCH_STEPS) begin
            mode                = qrg_pkg::MODE_RIGHT;
            ccw_turns           = '0;
            r.translate_restart = 1'b1;
        end
        if (ccw_steps >= qrg_pkg::LATCH_STEPS) begin
            mode                = qrg_pkg::MODE_LEFT;
            cw_turns            = '0;
            r.translate_restart = 1'b1;
        end
        if (ccw_moved && mode == qrg_pkg::MODE_LEFT
                && ccw_steps[1:0] == qrg_pkg::TURN_PHASE) begin
            ccw_turns    = bump16(ccw_turns);
            r.turn_pulse = 1'b1;
        end
        if (cw_moved && mode == qrg_pkg::MODE_RIGHT
                && cw_steps[1:0] == qrg_pkg::TURN_PHASE) begin
            cw_turns     = bump16(cw_turns);
            r.turn_pulse = 1'b1;
        end
        r.rotation    = mode;
        r.turns_right = cw_turns;
        r.turns_left  = ccw_turns;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
            $display("%0t result %0d: %s got %0d expected %0d",
                     $time, result_index, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        result_index = 0;
        threshold    = qrg_pkg::THR_RESET;
        clear_gesture();
    end

    always @(posedge aclk) begin
        qrg_pkg::result_t got;
        qrg_pkg::result_t want;
        if (!aresetn) begin
            threshold = qrg_pkg::THR_RESET;
            clear_gesture();
            expected_gesture_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[35:0];
                if (expected_gesture_results.size() == 0) begin
                    report_mismatch("unexpected transaction, data", m_tdata, 0);
                end else begin
                    want = expected_gesture_results.pop_front();
                    if (got.rotation != want.rotation)
                        report_mismatch("rotation", got.rotation, want.rotation);
                    if (got.turns_right != want.turns_right)
                        report_mismatch("turns_right", got.turns_right, want.turns_right);
                    if (got.turns_left != want.turns_left)
                        report_mismatch("turns_left", got.turns_left, want.turns_left);
                    if (got.turn_pulse != want.turn_pulse)
                        report_mismatch("turn_pulse", got.turn_pulse, want.turn_pulse);
                    if (got.translate_restart != want.translate_restart)
                        report_mismatch("translate_restart", got.translate_restart,
                                        want.translate_restart);
                    if (m_tdata[39:36] != '0)
                        report_mismatch("pad bits", m_tdata[39:36], 0);
                end
                result_index++;
            end
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (s_tvalid && s_tready)
                expected_gesture_results.push_back(
                    predict_gesture(s_tdata[15:0], s_tdata[31:16], s_tuser));
        end
        outstanding = expected_gesture_results.size();
    end

endmodule

// ===== sim/tb.sv =====
// tb: drives cursor samples and threshold writes into the quadrant rotation gesture
// detector under changing idle patterns, and gives the verdict.
// Depends on qrg_pkg, quadrant_rotation_gesture_detector and gesture_result_checker.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 90;
    localparam int SWEEP_STEPS = 40;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [14:0] cfg_data  = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [39:0] m_tdata;
    wire logic        cfg_ready;

    int mismatches;
    int outstanding;
    int send_idle_pct = 36;
    int recv_idle_pct = 74;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int samples_sent  = 0;
    int thr_now       = int'(qrg_pkg::THR_RESET);

    always #4 aclk = ~aclk;

    quadrant_rotation_gesture_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gesture_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_sample(input int x, input int y, input logic idle);
        logic [15:0] xb;
        logic [15:0] yb;
        xb = x[15:0];
        yb = y[15:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yb, xb};
        s_tuser  <= idle;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    task automatic set_threshold(input int v);
        drain();
        repeat (3) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[14:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        thr_now = v;
    endtask

    // a coordinate strictly beyond the threshold on the given side, where one exists
    function automatic int beyond(input bit neg);
        int mag;
        if (thr_now >= 32767)
            return neg ? -32768 : 32767;
        if (neg && $urandom_range(15) == 0)
            return -32768;
        case ($urandom_range(7))
            0:       mag = thr_now + 1;
            1:       mag = 32767;
            default: mag = $urandom_range(32767, thr_now + 1);
        endcase
        return neg ? -mag : mag;
    endfunction

    function automatic int short_of();
        if (thr_now == 0)
            return 0;
        return int'($urandom_range(2 * thr_now)) - thr_now;
    endfunction

    task automatic visit(input int q, input logic idle);
        bit xneg;
        bit yneg;
        xneg = (q == int'(qrg_pkg::QUAD_MM) || q == int'(qrg_pkg::QUAD_MP));
        yneg = (q == int'(qrg_pkg::QUAD_PM) || q == int'(qrg_pkg::QUAD_MM));
        push_sample(beyond(xneg), beyond(yneg), idle);
    endtask

    task automatic push_noise(input logic idle);
        push_sample(int'($urandom_range(65535)) - 32768,
                    int'($urandom_range(65535)) - 32768, idle);
    endtask

    task automatic random_gesture();
        int q;
        int dir;
        int len;
        int r;
        q = $urandom_range(3);
        r = $urandom_range(9);
        if (r < 7)
            visit(q, 1'b1);
        else if (r < 9)
            push_noise(1'b1);
        dir = $urandom_range(1) ? 1 : 3;
        len = $urandom_range(16, 1);
        repeat (len) begin
            r = $urandom_range(19);
            case (r)
                0: dir = 4 - dir;
                1: push_noise($urandom_range(7) == 0);
                2: push_sample(short_of(), short_of(), 1'b0);
                3: visit((q + 2) % 4, 1'b0);
                4: visit(q, 1'b0);
                default: ;
            endcase
            q = (q + dir) % 4;
            visit(q, 1'b0);
        end
    endtask

    task automatic run_gestures(input int count);
        int stop_at;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
            random_gesture();
    endtask

    initial begin
        int q;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset threshold: boundaries, idle entry, right latch, then left latch
        push_sample(-32768, 32767, 1'b1);
        push_sample(64, 65, 1'b0);
        push_sample(65, -65, 1'b0);
        push_sample(65, 65, 1'b0);
        for (q = 1; q <= 6; q++)
            visit(q % 4, 1'b0);
        for (q = 6; q >= 0; q--)
            visit((q + 4) % 4, 1'b0);
        push_sample(32767, 32767, 1'b0);
        push_sample(0, 0, 1'b1);
        push_sample(-32768, -32768, 1'b0);
        push_sample(-65, 65, 1'b0);
        push_sample(-1, 1, 1'b1);

        set_threshold(0);
        run_gestures(150);
        hold_requests++;
        run_gestures(40);
        drain();
        run_gestures(60);

        set_threshold(32767);
        push_sample(32767, 32767, 1'b0);
        push_sample(-32768, -32768, 1'b1);
        push_sample(-32768, -32767, 1'b0);
        push_sample(-32768, 32767, 1'b0);
        push_sample(-32767, -32768, 1'b0);

        set_threshold($urandom_range(3000));
        send_idle_pct = 74;
        recv_idle_pct = 36;
        run_gestures(200);
        set_threshold($urandom_range(32766));
        run_gestures(40);
        set_threshold($urandom_range(500));
        run_gestures(60);

        set_threshold(int'(qrg_pkg::THR_RESET));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_gestures(200);
        hold_requests++;
        run_gestures(50);
        drain();
        run_gestures(50);

        // long clockwise sweep, many full turns in a row
        q = $urandom_range(3);
        visit(q, 1'b1);
        repeat (SWEEP_STEPS) begin
            q = (q + 1) % 4;
            visit(q, 1'b0);
        end
        run_gestures(30);

        drain();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
